// ===== sv/csl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the c subset lexer
// Token kinds, scanner modes and the token list handed from the scanner
// to the result buffer.
// ----------------------------------------------------------------------------
package csl_pkg;

   localparam int CharWidth  = 8;
   localparam int ValueWidth = 31;
   localparam int KindWidth  = 4;
   localparam int MaxTokens  = 3;
   localparam int RspWidth   = 40;

   localparam logic [ValueWidth-1:0] ValueMax = {ValueWidth{1'b1}};

   // scanner modes
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_LIT  = 2'd1,
      MODE_NAME = 2'd2,
      MODE_SKIP = 2'd3
   } mode_type;

   // token kinds as seen on the result channel
   typedef enum logic [KindWidth-1:0] {
      TK_LBRACE = 4'd0,
      TK_RBRACE = 4'd1,
      TK_LPAREN = 4'd2,
      TK_RPAREN = 4'd3,
      TK_SEMI   = 4'd4,
      TK_INT    = 4'd5,
      TK_RET    = 4'd6,
      TK_IDENT  = 4'd7,
      TK_LIT    = 4'd8,
      TK_MAIN   = 4'd9,
      TK_END    = 4'd10,
      TK_ERROR  = 4'd11
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [ValueWidth-1:0] value;
      logic                  ovf;
   } tok_type;

   // up to three tokens caused by one character, slot 0 goes out first
   typedef struct packed {
      tok_type [MaxTokens-1:0] tok;
      logic [1:0]              count;
   } token_list_type;

endpackage

// ===== sv/c_subset_lexer.sv =====
`timescale 1ns / 1ps
// A token passes the character register and then the result buffer.
// Throughput: one character per cycle while the result buffer is free; the
// k tokens (k up to 3) of one character go out one per cycle on rsp_tready.
// Reset: synchronous, active high; clears the scanner to idle between tokens
// and empties both the character register and the result buffer.
// ----------------------------------------------------------------------------
// c_subset_lexer: streaming tokenizer for a small c subset
// Character register and scanner, then a token buffer that drives results.
// ----------------------------------------------------------------------------
module c_subset_lexer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // ch
   input  logic                          req_tlast,  // end_of_text
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [csl_pkg::RspWidth-1:0]  rsp_tdata,  // token_kind, token_value, overflow
   output logic                          rsp_tlast   // last_of_run
);

   logic                    load_valid;
   logic                    load_ready;
   csl_pkg::token_list_type load_list;

   // scanner
   csl_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .load_ready (load_ready),
      .load_valid (load_valid),
      .load_list  (load_list)
   );

   // result buffer
   csl_tokq u_tokq (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_list  (load_list),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/csl_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_scan: character register and scanner state
// Holds one character, classifies it against the scanner state and builds
// the list of tokens it causes in a single pass.
// ----------------------------------------------------------------------------
module csl_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // ch
   input  logic                     req_tlast,   // end_of_text
   input  logic                     load_ready,
   output logic                     load_valid,
   output csl_pkg::token_list_type  load_list
);

   localparam logic [47:0] KwInt    = 48'h0000_0069_6E74;
   localparam logic [47:0] KwMain   = 48'h0000_6D61_696E;
   localparam logic [47:0] KwReturn = 48'h7265_7475_726E;

   // input register
   logic                            s1_valid_ff, s1_valid_in;
   logic [csl_pkg::CharWidth-1:0]   s1_ch_ff;
   logic                            s1_last_ff;

   // scanner state
   csl_pkg::mode_type               mode_ff, mode_in;
   logic [csl_pkg::ValueWidth-1:0]  acc_ff, acc_in;
   logic                            sat_ff, sat_in;
   logic [47:0]                     prefix_ff, prefix_in;
   logic [2:0]                      len_ff, len_in;

   logic                            advance;
   logic                            accept;

   // flush a pending literal or name into a token
   function automatic csl_pkg::tok_type flush_tok(
      input csl_pkg::mode_type              mode,
      input logic [csl_pkg::ValueWidth-1:0] acc,
      input logic                           sat,
      input logic [47:0]                    prefix,
      input logic [2:0]                     len
   );
      csl_pkg::tok_type t;
      t.kind  = csl_pkg::TK_IDENT;
      t.value = '0;
      t.ovf   = 1'b0;
      if (mode == csl_pkg::MODE_LIT) begin
         t.kind  = csl_pkg::TK_LIT;
         t.value = acc;
         t.ovf   = sat;
      end else if (len == 3'd3 && prefix == KwInt) begin
         t.kind = csl_pkg::TK_INT;
      end else if (len == 3'd4 && prefix == KwMain) begin
         t.kind = csl_pkg::TK_MAIN;
      end else if (len == 3'd6 && prefix == KwReturn) begin
         t.kind = csl_pkg::TK_RET;
      end
      return t;
   endfunction

   // character classes and token building
   logic                            is_digit, is_alpha, is_sep, is_punct, is_err;
   logic                            cont, pending;
   logic [3:0]                      digit;
   logic [csl_pkg::ValueWidth+3:0]  acc_x10;
   csl_pkg::kind_type               punct_kind;
   csl_pkg::mode_type               mode_new;
   logic [csl_pkg::ValueWidth-1:0]  acc_new;
   logic                            sat_new;
   logic [47:0]                     prefix_new;
   logic [2:0]                      len_new;
   csl_pkg::tok_type                cand_tok [4];
   logic [3:0]                      cand_use;
   logic [1:0]                      n;

   always_comb begin
      is_digit = s1_ch_ff >= "0" && s1_ch_ff <= "9";
      is_alpha = (s1_ch_ff >= "A" && s1_ch_ff <= "Z") || (s1_ch_ff >= "a" && s1_ch_ff <= "z");
      is_sep   = s1_ch_ff == " " || s1_ch_ff == 8'h09 || s1_ch_ff == 8'h0A;
      is_punct   = 1'b1;
      punct_kind = csl_pkg::TK_SEMI;
      unique case (s1_ch_ff)
         ";":     punct_kind = csl_pkg::TK_SEMI;
         "(":     punct_kind = csl_pkg::TK_LPAREN;
         ")":     punct_kind = csl_pkg::TK_RPAREN;
         "{":     punct_kind = csl_pkg::TK_LBRACE;
         "}":     punct_kind = csl_pkg::TK_RBRACE;
         default: is_punct = 1'b0;
      endcase
      is_err  = !(is_digit || is_alpha || is_sep || is_punct);
      digit   = s1_ch_ff[3:0];
      cont    = (mode_ff == csl_pkg::MODE_NAME && (is_alpha || is_digit)) ||
                (mode_ff == csl_pkg::MODE_LIT && is_digit);
      pending = mode_ff == csl_pkg::MODE_LIT || mode_ff == csl_pkg::MODE_NAME;

      // literal accumulate, acc * 10 as two shifts and an add
      acc_x10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {31'd0, digit};

      // state after this character
      mode_new   = csl_pkg::MODE_IDLE;
      acc_new    = '0;
      sat_new    = 1'b0;
      prefix_new = '0;
      len_new    = '0;
      if (cont && mode_ff == csl_pkg::MODE_LIT) begin
         mode_new   = csl_pkg::MODE_LIT;
         if (acc_x10 > {4'd0, csl_pkg::ValueMax}) begin
            acc_new = csl_pkg::ValueMax;
            sat_new = 1'b1;
         end else begin
            acc_new = acc_x10[csl_pkg::ValueWidth-1:0];
            sat_new = sat_ff;
         end
      end else if (cont) begin
         mode_new   = csl_pkg::MODE_NAME;
         prefix_new = (len_ff < 3'd6) ? {prefix_ff[39:0], s1_ch_ff} : prefix_ff;
         len_new    = (len_ff < 3'd7) ? len_ff + 3'd1 : len_ff;
      end else if (is_digit) begin
         mode_new = csl_pkg::MODE_LIT;
         acc_new  = {27'd0, digit};
      end else if (is_alpha) begin
         mode_new   = csl_pkg::MODE_NAME;
         prefix_new = {40'd0, s1_ch_ff};
         len_new    = 3'd1;
      end

      // candidate tokens in output order
      cand_tok[0] = flush_tok(mode_ff, acc_ff, sat_ff, prefix_ff, len_ff);
      cand_use[0] = !cont && pending;
      cand_tok[1] = '{kind: is_err ? csl_pkg::TK_ERROR : punct_kind, value: '0, ovf: 1'b0};
      cand_use[1] = !cont && (is_punct || is_err);
      cand_tok[2] = flush_tok(mode_new, acc_new, sat_new, prefix_new, len_new);
      cand_use[2] = s1_last_ff && !is_err && mode_new != csl_pkg::MODE_IDLE;
      cand_tok[3] = '{kind: csl_pkg::TK_END, value: '0, ovf: 1'b0};
      cand_use[3] = s1_last_ff && !is_err;
      if (mode_ff == csl_pkg::MODE_SKIP) begin
         cand_use = '0;
      end

      // pack used candidates into the list
      load_list = '0;
      n = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_use[i] && n < 2'd3) begin
            load_list.tok[n] = cand_tok[i];
            n = n + 2'd1;
         end
      end
      load_list.count = n;

      advance     = s1_valid_ff && (n == 2'd0 || load_ready);
      load_valid  = s1_valid_ff && n != 2'd0 && load_ready;
      req_tready  = !s1_valid_ff || advance;
      accept      = req_tvalid && req_tready;
      s1_valid_in = accept || (s1_valid_ff && !advance);

      // next scanner state
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      if (advance) begin
         if (s1_last_ff) begin
            mode_in   = csl_pkg::MODE_IDLE;
            acc_in    = '0;
            sat_in    = 1'b0;
            prefix_in = '0;
            len_in    = '0;
         end else if (mode_ff == csl_pkg::MODE_SKIP) begin
            mode_in = csl_pkg::MODE_SKIP;
         end else if (is_err) begin
            mode_in   = csl_pkg::MODE_SKIP;
            acc_in    = '0;
            sat_in    = 1'b0;
            prefix_in = '0;
            len_in    = '0;
         end else begin
            mode_in   = mode_new;
            acc_in    = acc_new;
            sat_in    = sat_new;
            prefix_in = prefix_new;
            len_in    = len_new;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mode_ff     <= csl_pkg::MODE_IDLE;
         acc_ff      <= '0;
         sat_ff      <= 1'b0;
         prefix_ff   <= '0;
         len_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         sat_ff      <= sat_in;
         prefix_ff   <= prefix_in;
         len_ff      <= len_in;
      end
   end

   // character payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff   <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

endmodule

// ===== sv/csl_tokq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_tokq: result token buffer
// Holds the token list of one character and hands out one token per cycle
// under rsp_tready; a new list loads in the cycle the last token is taken.
// ----------------------------------------------------------------------------
module csl_tokq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load_valid,
   input  csl_pkg::token_list_type         load_list,
   output logic                            load_ready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [csl_pkg::RspWidth-1:0]    rsp_tdata,  // token_kind, token_value, overflow
   output logic                            rsp_tlast   // last_of_run
);

   csl_pkg::tok_type [csl_pkg::MaxTokens-1:0] tok_ff;
   logic [1:0]  cnt_ff;
   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic        pop;
   csl_pkg::tok_type cur;

   // output selection and load handshake
   always_comb begin
      cur        = tok_ff[idx_ff];
      rsp_tvalid = valid_ff;
      rsp_tlast  = idx_ff == cnt_ff - 2'd1;
      rsp_tdata  = {4'd0, cur.ovf, cur.value, cur.kind};
      pop        = valid_ff && rsp_tready;
      load_ready = !valid_ff || (pop && rsp_tlast);
      valid_in   = valid_ff;
      idx_in     = idx_ff;
      if (load_valid) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (pop && rsp_tlast) begin
         valid_in = 1'b0;
      end else if (pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      if (load_valid) begin
         tok_ff <= load_list.tok;
         cnt_ff <= load_list.count;
      end
   end

endmodule

// ===== sv/csl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_checker: port level checks for the c subset lexer
// Watches the result channel for token rules and stall behavior.
// ----------------------------------------------------------------------------
module csl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [csl_pkg::RspWidth-1:0] rsp_tdata,
   input logic                         rsp_tlast
);

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled item changed");

   // only literals carry a value or overflow
   a_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] != csl_pkg::TK_LIT |-> rsp_tdata[35:4] == '0)
      else $error("value on non-literal token");

   // overflow means the value sits at the ceiling
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[34:4] == csl_pkg::ValueMax)
      else $error("overflow without saturated value");

   // end and error tokens close their run
   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:0] == csl_pkg::TK_END || rsp_tdata[3:0] == csl_pkg::TK_ERROR)
      |-> rsp_tlast)
      else $error("end or error token not last of run");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/c_subset_lexer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_lexer_tb: self-checking bench for the c subset lexer
// Feeds source characters on the request stream and compares every token on
// the response stream against an in-bench scanner model. A short directed
// table comes first, then random texts built from tokens, separators and
// stray bytes, run under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module c_subset_lexer_tb;

   localparam int RandomItems = 310;
   localparam int DrainCycles = 10;
   localparam int HoldCycles  = 80;
   localparam int IdleLimit   = 2000;
   localparam int PrintLimit  = 40;

   // names that map to keyword tokens, right-justified ascii
   localparam logic [47:0] NameInt    = "int";
   localparam logic [47:0] NameMain   = "main";
   localparam logic [47:0] NameReturn = "return";

   // one expected token, last marks the final token of its character
   typedef struct packed {
      csl_pkg::kind_type              kind;
      logic [csl_pkg::ValueWidth-1:0] value;
      logic                           ovf;
      logic                           last;
   } lex_token_type;

   // directed row; typed rows cause exactly the given token, value zero
   typedef struct packed {
      logic [7:0]        ch;
      logic              eot;
      logic              typed;
      csl_pkg::kind_type kind;
   } dir_row_type;

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata  = 8'h00;  // ch
   logic                         req_tlast  = 1'b0;   // end_of_text
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [csl_pkg::RspWidth-1:0] rsp_tdata;  // token_kind, token_value, overflow
   logic                         rsp_tlast;  // last_of_run

   // scanner model state
   csl_pkg::mode_type              scan_mode = csl_pkg::MODE_IDLE;
   logic [csl_pkg::ValueWidth-1:0] lit_acc   = '0;
   logic                           lit_sat   = 1'b0;
   logic [47:0]                    name_buf  = '0;
   logic [2:0]                     name_len  = '0;

   lex_token_type tokens_due [$];
   lex_token_type step_tokens [$];
   logic [7:0]    text_chars [$];

   int fail_count     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit long_hold_due  = 1'b0;

   dir_row_type dir_table [0:24] = '{
      '{";",   1'b0, 1'b1, csl_pkg::TK_SEMI},
      '{"(",   1'b0, 1'b1, csl_pkg::TK_LPAREN},
      '{")",   1'b0, 1'b1, csl_pkg::TK_RPAREN},
      '{"{",   1'b0, 1'b1, csl_pkg::TK_LBRACE},
      '{"}",   1'b0, 1'b1, csl_pkg::TK_RBRACE},
      '{"m",   1'b0, 1'b0, csl_pkg::TK_END},   // kind unused on untyped rows
      '{"a",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"i",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"n",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"\n",  1'b0, 1'b0, csl_pkg::TK_END},
      '{"1",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"2",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"a",   1'b0, 1'b0, csl_pkg::TK_END},   // literal ends at a letter
      '{"b",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"\t",  1'b0, 1'b0, csl_pkg::TK_END},
      '{8'h00, 1'b0, 1'b1, csl_pkg::TK_ERROR},
      '{"x",   1'b0, 1'b0, csl_pkg::TK_END},   // discarded after the error
      '{";",   1'b1, 1'b0, csl_pkg::TK_END},   // discarded, back to idle
      '{8'hFF, 1'b1, 1'b1, csl_pkg::TK_ERROR}, // flagged error, no end token
      '{"z",   1'b0, 1'b0, csl_pkg::TK_END},
      '{";",   1'b1, 1'b0, csl_pkg::TK_END},   // ident, semi and end from one item
      '{" ",   1'b1, 1'b1, csl_pkg::TK_END},
      '{"i",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"n",   1'b0, 1'b0, csl_pkg::TK_END},
      '{"t",   1'b1, 1'b0, csl_pkg::TK_END}
   };

   c_subset_lexer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_failure(input string msg);
      if (fail_count < PrintLimit) begin
         $display("mismatch: %s", msg);
      end
      fail_count++;
   endtask

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic void add_token(input csl_pkg::kind_type k,
                                     input logic [csl_pkg::ValueWidth-1:0] v,
                                     input logic o);
      lex_token_type t;
      t.kind  = k;
      t.value = v;
      t.ovf   = o;
      t.last  = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void clear_scan();
      scan_mode = csl_pkg::MODE_IDLE;
      lit_acc   = '0;
      lit_sat   = 1'b0;
      name_buf  = '0;
      name_len  = '0;
   endfunction

   // value saturates at the largest 31-bit number
   function automatic void add_digit(input logic [7:0] c);
      longint unsigned v;
      v = longint'(lit_acc) * 10 + longint'(c - "0");
      if (v > longint'(csl_pkg::ValueMax)) begin
         v       = longint'(csl_pkg::ValueMax);
         lit_sat = 1'b1;
      end
      lit_acc = v[csl_pkg::ValueWidth-1:0];
   endfunction

   // keep the first six characters, length saturates at seven
   function automatic void add_name_char(input logic [7:0] c);
      if (name_len < 3'd6) begin
         name_buf = {name_buf[39:0], c};
      end
      if (name_len < 3'd7) begin
         name_len++;
      end
   endfunction

   // emit the pending literal or name, keywords need an exact match
   function automatic void flush_pending();
      csl_pkg::kind_type k;
      if (scan_mode == csl_pkg::MODE_LIT) begin
         add_token(csl_pkg::TK_LIT, lit_acc, lit_sat);
      end else if (scan_mode == csl_pkg::MODE_NAME) begin
         k = csl_pkg::TK_IDENT;
         if (name_len == 3'd3 && name_buf == NameInt) begin
            k = csl_pkg::TK_INT;
         end else if (name_len == 3'd4 && name_buf == NameMain) begin
            k = csl_pkg::TK_MAIN;
         end else if (name_len == 3'd6 && name_buf == NameReturn) begin
            k = csl_pkg::TK_RET;
         end
         add_token(k, '0, 1'b0);
      end
      clear_scan();
   endfunction

   // advance the scanner by one character, queue its tokens, return their count
   function automatic int scan_char(input logic [7:0] c, input logic eot);
      bit errored;
      errored = 1'b0;
      step_tokens.delete();
      if (scan_mode == csl_pkg::MODE_SKIP) begin
         if (eot) begin
            clear_scan();
         end
         return 0;
      end
      if (scan_mode == csl_pkg::MODE_NAME && (is_alpha(c) || is_digit(c))) begin
         add_name_char(c);
      end else if (scan_mode == csl_pkg::MODE_LIT && is_digit(c)) begin
         add_digit(c);
      end else begin
         flush_pending();
         if (is_digit(c)) begin
            scan_mode = csl_pkg::MODE_LIT;
            add_digit(c);
         end else if (is_alpha(c)) begin
            scan_mode = csl_pkg::MODE_NAME;
            add_name_char(c);
         end else begin
            case (c)
               ";":           add_token(csl_pkg::TK_SEMI, '0, 1'b0);
               "(":           add_token(csl_pkg::TK_LPAREN, '0, 1'b0);
               ")":           add_token(csl_pkg::TK_RPAREN, '0, 1'b0);
               "{":           add_token(csl_pkg::TK_LBRACE, '0, 1'b0);
               "}":           add_token(csl_pkg::TK_RBRACE, '0, 1'b0);
               " ", "\t", "\n": ;
               default: begin
                  add_token(csl_pkg::TK_ERROR, '0, 1'b0);
                  errored   = 1'b1;
                  scan_mode = eot ? csl_pkg::MODE_IDLE : csl_pkg::MODE_SKIP;
               end
            endcase
         end
      end
      if (eot && !errored) begin
         flush_pending();
         add_token(csl_pkg::TK_END, '0, 1'b0);
      end
      if (step_tokens.size() > 0) begin
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      end
      foreach (step_tokens[i]) begin
         tokens_due.push_back(step_tokens[i]);
      end
      return step_tokens.size();
   endfunction

   // offer one item, with random sender idling before it
   task automatic offer_char(input logic [7:0] c, input logic eot);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic void append_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_chars.push_back(s[i]);
      end
   endfunction

   function automatic logic [7:0] random_name_char(input bit allow_digit);
      int k;
      k = $urandom_range(0, allow_digit ? 61 : 51);
      if (k < 26) return 8'("A" + k);
      if (k < 52) return 8'("a" + k - 26);
      return 8'("0" + k - 52);
   endfunction

   // one piece of text: punctuation, name, literal, separator or stray byte
   function automatic void add_piece();
      int pick;
      int n;
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
         case ($urandom_range(0, 4))
            0: text_chars.push_back(";");
            1: text_chars.push_back("(");
            2: text_chars.push_back(")");
            3: text_chars.push_back("{");
            default: text_chars.push_back("}");
         endcase
      end else if (pick < 6) begin
         case ($urandom_range(0, 7))
            0: append_string("int");
            1: append_string("main");
            2: append_string("return");
            3: append_string("in");
            4: append_string("mainx");
            5: append_string("returnx");
            6: append_string("inte");
            default: append_string("Int");
         endcase
      end else if (pick < 8) begin
         n = $urandom_range(0, 8);
         text_chars.push_back(random_name_char(1'b0));
         repeat (n) text_chars.push_back(random_name_char(1'b1));
      end else if (pick < 12) begin
         case ($urandom_range(0, 5))
            0: append_string("2147483647");
            1: append_string("2147483648");
            2: append_string("0");
            default: begin
               n = $urandom_range(1, 12);
               repeat (n) text_chars.push_back(8'("0" + $urandom_range(0, 9)));
            end
         endcase
      end else if (pick < 17) begin
         case ($urandom_range(0, 2))
            0: text_chars.push_back(" ");
            1: text_chars.push_back("\t");
            default: text_chars.push_back("\n");
         endcase
      end else if (pick < 19) begin
         text_chars.push_back(" ");
      end else begin
         text_chars.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // response side: random stalls, one long hold on request, token check
   initial begin
      lex_token_type     want;
      csl_pkg::kind_type got_kind;
      forever begin
         if (long_hold_due) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            long_hold_due = 1'b0;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_kind = csl_pkg::kind_type'(rsp_tdata[3:0]);
            if (tokens_due.size() == 0) begin
               note_failure($sformatf("token kind %0d with nothing due", got_kind));
            end else begin
               want = tokens_due.pop_front();
               if (got_kind != want.kind) begin
                  note_failure($sformatf("kind %0d, expected %0d", got_kind, want.kind));
               end
               if (rsp_tdata[34:4] != want.value) begin
                  note_failure($sformatf("value %0d, expected %0d",
                                         rsp_tdata[34:4], want.value));
               end
               if (rsp_tdata[35] != want.ovf) begin
                  note_failure($sformatf("overflow %0b, expected %0b",
                                         rsp_tdata[35], want.ovf));
               end
               if (rsp_tlast != want.last) begin
                  note_failure($sformatf("last %0b, expected %0b", rsp_tlast, want.last));
               end
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   // stimulus
   initial begin
      int fed;
      int pushed;
      int phase;
      int last_phase;
      lex_token_type typed_tok;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_table[i]) begin
         offer_char(dir_table[i].ch, dir_table[i].eot);
         pushed = scan_char(dir_table[i].ch, dir_table[i].eot);
         if (dir_table[i].typed) begin
            repeat (pushed) void'(tokens_due.pop_back());
            typed_tok.kind  = dir_table[i].kind;
            typed_tok.value = '0;
            typed_tok.ovf   = 1'b0;
            typed_tok.last  = 1'b1;
            tokens_due.push_back(typed_tok);
         end
      end
      drain_results();

      // random texts under rotating idling phases
      fed        = 0;
      last_phase = -1;
      long_hold_due = 1'b1;
      while (fed < RandomItems) begin
         phase = fed * 4 / RandomItems;
         if (phase != last_phase) begin
            if (phase == 2) begin
               drain_results();
            end
            case (phase)
               0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
               2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
               default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            last_phase = phase;
         end
         text_chars.delete();
         repeat ($urandom_range(1, 12)) add_piece();
         foreach (text_chars[i]) begin
            offer_char(text_chars[i], i == text_chars.size() - 1);
            void'(scan_char(text_chars[i], i == text_chars.size() - 1));
            fed++;
         end
      end
      drain_results();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
